### design/hcsf_pkg.sv
// ----------------------------------------------------------------------------
// hcsf_pkg
// Shared types and constants for the Hall current sense filter.
// ----------------------------------------------------------------------------
package hcsf_pkg;

  // Default number of samples summed per block
  localparam int BLOCK_SAMPLES_DEFAULT = 32;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 17;
  localparam int MA_W     = 19;
  localparam int GAIN_W   = 20;
  localparam int ALPHA_W  = 9;
  localparam int CFG_W    = 20;
  localparam int IDX_W    = 1;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_GAIN  = 1'd0;
  localparam logic [IDX_W-1:0] REG_ALPHA = 1'd1;

  // Reset values
  localparam logic [GAIN_W-1:0]  GAIN_RESET      = 20'd125030;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 9'd51;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE       = 9'd256;
  localparam logic [SUM_W-1:0]   QUIESCENT_RESET = 17'd61946;
  localparam logic [SUM_W-1:0]   SUM_MAX         = 17'd131071;

  // Current limit, at the width of the shifted gain product
  localparam logic signed [21:0] MA_LIMIT = 22'sd250000;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // take the input item and accumulate it
    logic mul_gain;  // product <= (sum - offset) * gain
    logic sat;       // raw current <= saturated (product >>> 16)
    logic mul_ema;   // product <= alpha * (raw - filtered)
    logic load;      // update state and load the output register
  } hcsf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic done;      // the offered sample closes its channel's block
    logic out_free;  // output register can take a result this cycle
  } hcsf_sts_t;

  // Clamp a current to +-250000 mA
  function automatic logic signed [MA_W-1:0] sat_ma(input logic signed [21:0] v);
    logic signed [21:0] c;
    c = v;
    if (v > MA_LIMIT) c = MA_LIMIT;
    if (v < -MA_LIMIT) c = -MA_LIMIT;
    return c[MA_W-1:0];
  endfunction

endpackage

### design/hcsf_ctrl.sv
// ----------------------------------------------------------------------------
// hcsf_ctrl
// Sequencer: accepts samples and steps the end-of-block computation.
// ----------------------------------------------------------------------------
module hcsf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  hcsf_pkg::hcsf_sts_t sts,
  output hcsf_pkg::hcsf_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_MUL_GAIN = 5'b00010,
    S_SAT      = 5'b00100,
    S_MUL_EMA  = 5'b01000,
    S_LOAD     = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && sts.done) state_next = S_MUL_GAIN;
      end
      S_MUL_GAIN: begin
        cmd.mul_gain = 1'b1;
        state_next   = S_SAT;
      end
      S_SAT: begin
        cmd.sat    = 1'b1;
        state_next = S_MUL_EMA;
      end
      S_MUL_EMA: begin
        cmd.mul_ema = 1'b1;
        state_next  = S_LOAD;
      end
      S_LOAD: begin
        // hold until the output register frees up
        cmd.load = sts.out_free;
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  a_done_starts_mul: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && sts.done) |=> (state == S_MUL_GAIN))
    else $error("block end did not start the gain multiply");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> sts.out_free)
    else $error("result loaded while output register full");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.mul_gain || cmd.sat || cmd.mul_ema || cmd.load) |-> !cmd.accept)
    else $error("sample accepted during block computation");

endmodule

### design/hcsf_dp.sv
// ----------------------------------------------------------------------------
// hcsf_dp
// Datapath: per-channel accumulators, shared multiplier, EMA filter,
// calibration offset and the output register.
// ----------------------------------------------------------------------------
module hcsf_dp #(
  parameter int BLOCK_SAMPLES = hcsf_pkg::BLOCK_SAMPLES_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [hcsf_pkg::IDX_W-1:0]          cfg_index,
  input  logic [hcsf_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                mode,
  input  logic                                channel,
  input  logic [hcsf_pkg::SAMPLE_W-1:0]       sample,
  input  hcsf_pkg::hcsf_cmd_t                 cmd,
  output hcsf_pkg::hcsf_sts_t                 sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_channel,
  output logic [hcsf_pkg::SUM_W-1:0]          block_sum,
  output logic signed [hcsf_pkg::MA_W-1:0]    raw_current_ma,
  output logic signed [hcsf_pkg::MA_W-1:0]    filtered_current_ma,
  output logic                                calibrated,
  output logic [hcsf_pkg::SUM_W-1:0]          offset_sum
);

  localparam int CNT_W = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_SAMPLES - 1);

  localparam int SUM_W = hcsf_pkg::SUM_W;
  localparam int MA_W  = hcsf_pkg::MA_W;

  // Configuration
  logic [hcsf_pkg::GAIN_W-1:0]  gain_q16;
  logic [hcsf_pkg::ALPHA_W-1:0] ema_alpha_q8;

  // Channel state
  logic [SUM_W-1:0]       accum [2];
  logic [CNT_W-1:0]       sample_count [2];
  logic signed [MA_W-1:0] filtered_ma [2];
  logic [SUM_W-1:0]       quiescent_sum;
  logic [SUM_W-1:0]       solar_cal_sum;

  // Item under work
  logic                   item_mode;
  logic                   item_ch;
  logic [SUM_W-1:0]       sum_reg;
  logic signed [37:0]     prod;
  logic signed [MA_W-1:0] raw_ma;

  logic [SUM_W:0]         sum_wide;
  logic [SUM_W-1:0]       sum_sat;
  logic signed [SUM_W:0]  diff;
  logic signed [MA_W:0]   delta;
  logic [hcsf_pkg::ALPHA_W-1:0] alpha;
  logic signed [20:0]     op_a, op_b;
  logic signed [41:0]     prod_full;
  logic signed [MA_W:0]   f_step;
  logic signed [MA_W:0]   f_sum;
  logic signed [MA_W-1:0] f_next;
  logic [SUM_W:0]         cal_wide;
  logic [SUM_W-1:0]       q_next;
  logic                   do_cal;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_q16     <= hcsf_pkg::GAIN_RESET;
      ema_alpha_q8 <= hcsf_pkg::ALPHA_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hcsf_pkg::REG_GAIN:  gain_q16     <= cfg_data;
        hcsf_pkg::REG_ALPHA: ema_alpha_q8 <= cfg_data[hcsf_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // Accumulate the offered sample with saturation
  assign sum_wide     = {1'b0, accum[channel]} + {{(SUM_W + 1 - hcsf_pkg::SAMPLE_W){1'b0}}, sample};
  assign sum_sat      = sum_wide[SUM_W] ? hcsf_pkg::SUM_MAX : sum_wide[SUM_W-1:0];
  assign sts.done     = (sample_count[channel] == CNT_LAST);
  assign sts.out_free = !out_valid || !out_stall;

  // Shared multiplier operands
  assign diff  = $signed({1'b0, sum_reg}) - $signed({1'b0, quiescent_sum});
  assign alpha = (ema_alpha_q8 > hcsf_pkg::ALPHA_ONE) ? hcsf_pkg::ALPHA_ONE : ema_alpha_q8;
  assign delta = MA_W'(0) + ($signed({raw_ma[MA_W-1], raw_ma})
                 - $signed({filtered_ma[item_ch][MA_W-1], filtered_ma[item_ch]}));

  always_comb begin
    if (cmd.mul_gain) begin
      op_a = 21'(diff);
      op_b = $signed({1'b0, gain_q16});
    end else begin
      op_a = 21'(delta);
      op_b = $signed({12'd0, alpha});
    end
  end

  assign prod_full = op_a * op_b;

  // EMA: f + floor(alpha * (raw - f) / 256); held in calibrate mode
  assign f_step = prod[27:8];
  assign f_sum  = $signed({filtered_ma[item_ch][MA_W-1], filtered_ma[item_ch]}) + f_step;
  assign f_next = item_mode ? filtered_ma[item_ch] : f_sum[MA_W-1:0];

  // Calibration offset
  assign do_cal   = item_mode && item_ch;
  assign cal_wide = {1'b0, solar_cal_sum} + {1'b0, sum_reg};
  assign q_next   = do_cal ? cal_wide[SUM_W:1] : quiescent_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        accum[i]        <= '0;
        sample_count[i] <= '0;
        filtered_ma[i]  <= '0;
      end
      quiescent_sum <= hcsf_pkg::QUIESCENT_RESET;
      solar_cal_sum <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (sts.done) begin
          accum[channel]        <= '0;
          sample_count[channel] <= '0;
        end else begin
          accum[channel]        <= sum_sat;
          sample_count[channel] <= sample_count[channel] + 1'b1;
        end
      end
      if (cmd.load) begin
        filtered_ma[item_ch] <= f_next;
        quiescent_sum        <= q_next;
        if (item_mode && !item_ch) solar_cal_sum <= sum_reg;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_mode <= mode;
      item_ch   <= channel;
      sum_reg   <= sum_sat;
    end
    if (cmd.mul_gain || cmd.mul_ema) prod <= prod_full[37:0];
    if (cmd.sat) raw_ma <= hcsf_pkg::sat_ma(prod[37:16]);
    if (cmd.load) begin
      out_channel         <= item_ch;
      block_sum           <= sum_reg;
      raw_current_ma      <= raw_ma;
      filtered_current_ma <= f_next;
      calibrated          <= do_cal;
      offset_sum          <= q_next;
    end
  end

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid)
    else $error("loaded result not presented");

  a_offset_stable: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && do_cal) |=> $stable(quiescent_sum))
    else $error("offset changed outside a battery calibration block");

  a_filter_range: assert property (@(posedge clk) disable iff (rst)
    (filtered_ma[0] <= 19'sd250000) && (filtered_ma[0] >= -19'sd250000) &&
    (filtered_ma[1] <= 19'sd250000) && (filtered_ma[1] >= -19'sd250000))
    else $error("filtered current out of range");

endmodule

### design/hall_current_sense_filter.sv
// ----------------------------------------------------------------------------
// hall_current_sense_filter
// Block-averaging Hall current sensor front end with offset calibration
// and a per-channel EMA filter.
// ----------------------------------------------------------------------------
// Samples tagged solar (channel 0) or battery (channel 1) are summed per
// channel over BLOCK_SAMPLES samples. A sample that does not close a block
// does not stall the input; the one that closes a block steps through
// accept, gain multiply, saturate, EMA multiply and load before the
// next sample is taken; gain and EMA share one multiplier. One result
// transaction comes per completed block: the block sum, the current
// ((sum - offset) * gain_q16) >>> 16 clamped to +-250000 mA, and the
// channel's filtered current after a Q8 EMA step. In calibrate mode the
// filter holds; a solar block records its sum and a battery block sets the
// offset to the floor average of that solar sum and its own. The output
// register lets a new sample in while a result waits; a closing sample
// holds in the load step until the previous result is taken. Write the
// configuration registers (0: gain_q16, 1: ema_alpha_q8) only while idle.
module hall_current_sense_filter #(
  parameter int BLOCK_SAMPLES = hcsf_pkg::BLOCK_SAMPLES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic [hcsf_pkg::IDX_W-1:0]        cfg_index,
  input  logic [hcsf_pkg::CFG_W-1:0]        cfg_data,
  // sample channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              mode,
  input  logic                              channel,
  input  logic [hcsf_pkg::SAMPLE_W-1:0]     sample,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_channel,
  output logic [hcsf_pkg::SUM_W-1:0]        block_sum,
  output logic signed [hcsf_pkg::MA_W-1:0]  raw_current_ma,
  output logic signed [hcsf_pkg::MA_W-1:0]  filtered_current_ma,
  output logic                              calibrated,
  output logic [hcsf_pkg::SUM_W-1:0]        offset_sum
);

  hcsf_pkg::hcsf_cmd_t cmd;
  hcsf_pkg::hcsf_sts_t sts;

  // Sequence the accept and end-of-block steps
  hcsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold channel state and compute the block results
  hcsf_dp #(
    .BLOCK_SAMPLES (BLOCK_SAMPLES)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write           (cfg_write),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .mode                (mode),
    .channel             (channel),
    .sample              (sample),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_channel         (out_channel),
    .block_sum           (block_sum),
    .raw_current_ma      (raw_current_ma),
    .filtered_current_ma (filtered_current_ma),
    .calibrated          (calibrated),
    .offset_sum          (offset_sum)
  );

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Hall current sense filter.
// ----------------------------------------------------------------------------
// Feed tagged ADC samples through the valid/stall sample port and check
// every block result against a local model of the block front end. The
// model covers the per-channel block sum, offset and gain, saturation, the
// Q8 EMA and the two-step offset calibration. A short table of whole blocks
// covers the extremes, mode changes inside a block and calibration. Random
// segments follow, each with its own register setting, signal levels and
// idle pattern. A final segment runs with no idling on either side.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int BLOCK_LEN = hcsf_pkg::BLOCK_SAMPLES_DEFAULT;

  localparam int SAMPLE_W = hcsf_pkg::SAMPLE_W;
  localparam int SUM_W    = hcsf_pkg::SUM_W;
  localparam int MA_W     = hcsf_pkg::MA_W;
  localparam int GAIN_W   = hcsf_pkg::GAIN_W;
  localparam int ALPHA_W  = hcsf_pkg::ALPHA_W;
  localparam int CFG_W    = hcsf_pkg::CFG_W;
  localparam int IDX_W    = hcsf_pkg::IDX_W;

  localparam logic [GAIN_W-1:0]  GAIN_RESET  = hcsf_pkg::GAIN_RESET;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = hcsf_pkg::ALPHA_RESET;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = hcsf_pkg::ALPHA_ONE;

  // Random segments stop once N_ITEMS - TAIL_LEN samples are sent; tail length
  localparam int N_ITEMS  = 900;
  localparam int TAIL_LEN = 128;

  // Input field codes
  localparam logic MODE_MEASURE = 1'b0;
  localparam logic MODE_CAL     = 1'b1;
  localparam logic CH_SOLAR     = 1'b0;
  localparam logic CH_BATTERY   = 1'b1;

  localparam logic [GAIN_W-1:0]  GAIN_MAX  = '1;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = '1;

  typedef struct packed {
    logic                    ch;
    logic [SUM_W-1:0]        sum;
    logic signed [MA_W-1:0]  raw;
    logic signed [MA_W-1:0]  filt;
    logic                    cal;
    logic [SUM_W-1:0]        off;
  } blk_result_t;

  // How a table row fills its block
  typedef enum logic [1:0] {
    PAT_CONST,    // every sample at the row level
    PAT_ALT,      // row level and its complement, alternating
    PAT_MIXMODE,  // row level, mode toggling so only the last sample sets it
    PAT_RANDOM    // uniform over the full ADC range
  } pattern_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain;
    logic [ALPHA_W-1:0]  alpha;
    pattern_t            pat;
    logic                mode;
    logic                ch;
    logic [SAMPLE_W-1:0] level;
    logic                has_exp;
    blk_result_t         want;
  } dir_row_t;

  localparam int DIR_ROWS = 12;

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic [IDX_W-1:0]           cfg_index;
  logic [CFG_W-1:0]           cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic                       mode;
  logic                       channel;
  logic [SAMPLE_W-1:0]        sample;
  logic                       out_valid;
  logic                       out_stall;
  logic                       out_channel;
  logic [SUM_W-1:0]           block_sum;
  logic signed [MA_W-1:0]     raw_current_ma;
  logic signed [MA_W-1:0]     filtered_current_ma;
  logic                       calibrated;
  logic [SUM_W-1:0]           offset_sum;

  hall_current_sense_filter u_top (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write           (cfg_write),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .mode                (mode),
    .channel             (channel),
    .sample              (sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_channel         (out_channel),
    .block_sum           (block_sum),
    .raw_current_ma      (raw_current_ma),
    .filtered_current_ma (filtered_current_ma),
    .calibrated          (calibrated),
    .offset_sum          (offset_sum)
  );

  // --------------------------------------------------------------------------
  // Model state: registers, per-channel accumulators and filters, offsets
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0]       gain_q;
  logic [ALPHA_W-1:0]      alpha_q;
  logic [SUM_W-1:0]        sum_acc [2];
  int                      sample_cnt [2];
  logic signed [MA_W-1:0]  filt_ma [2];
  logic [SUM_W-1:0]        offset_q;
  logic [SUM_W-1:0]        solar_zero;

  blk_result_t blocks_due [$];

  int  n_samples;
  int  n_blocks;
  int  n_cal;
  int  n_writes;
  int  n_checked;
  int  n_errors;
  bit  rx_idling;

  dir_row_t dir_table [DIR_ROWS];

  // Clamp to the +-250000 mA range of the current outputs
  function automatic logic signed [MA_W-1:0] clamp_ma(input longint v);
    if (v > 250000) return 19'sd250000;
    if (v < -250000) return -19'sd250000;
    return v[MA_W-1:0];
  endfunction

  // Fold one sample into its channel; return 1 with the result when the
  // sample closes a block.
  function automatic bit fold_sample(input logic m, input logic c,
                                     input logic [SAMPLE_W-1:0] s,
                                     output blk_result_t r);
    longint total;
    longint prod;
    longint wt;
    longint mix;
    logic signed [MA_W-1:0] raw;
    total = longint'(sum_acc[c]) + longint'(s);
    if (total > longint'(hcsf_pkg::SUM_MAX)) total = longint'(hcsf_pkg::SUM_MAX);
    sum_acc[c] = total[SUM_W-1:0];
    sample_cnt[c]++;
    r = '0;
    if (sample_cnt[c] < BLOCK_LEN) return 1'b0;
    sum_acc[c] = '0;
    sample_cnt[c] = 0;
    // arithmetic shift on a signed product is the floor division by 2^16
    prod = ((total - longint'(offset_q)) * longint'(gain_q)) >>> 16;
    raw = clamp_ma(prod);
    if (m == MODE_MEASURE) begin
      wt = (alpha_q > ALPHA_ONE) ? 256 : longint'(alpha_q);
      mix = wt * longint'(raw) + (256 - wt) * longint'(filt_ma[c]);
      filt_ma[c] = clamp_ma(mix >>> 8);
    end else if (c == CH_SOLAR) begin
      solar_zero = total[SUM_W-1:0];
    end else begin
      offset_q = SUM_W'((18'(solar_zero) + 18'(total[SUM_W-1:0])) >> 1);
      r.cal = 1'b1;
    end
    r.ch   = c;
    r.sum  = total[SUM_W-1:0];
    r.raw  = raw;
    r.filt = filt_ma[c];
    r.off  = offset_q;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    n_errors++;
  endtask

  // --------------------------------------------------------------------------
  // Clock and watchdog; reset and every input start in the main sequence
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: end the run if it hangs
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stall bursts if rx_idling, check each transaction
  // --------------------------------------------------------------------------
  int stall_left;

  always @(negedge clk) begin
    if (!rx_idling) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    blk_result_t got;
    blk_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{out_channel, block_sum, raw_current_ma, filtered_current_ma,
              calibrated, offset_sum};
      if (blocks_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: ch %0d sum %0d",
                                  got.ch, got.sum));
      end else begin
        want = blocks_due.pop_front();
        if (got.ch !== want.ch)
          report_mismatch($sformatf("result %0d out_channel got %0d want %0d",
                                    n_checked, got.ch, want.ch));
        if (got.sum !== want.sum)
          report_mismatch($sformatf("result %0d block_sum got %0d want %0d",
                                    n_checked, got.sum, want.sum));
        if (got.raw !== want.raw)
          report_mismatch($sformatf("result %0d raw_current_ma got %0d want %0d",
                                    n_checked, $signed(got.raw), $signed(want.raw)));
        if (got.filt !== want.filt)
          report_mismatch($sformatf("result %0d filtered_current_ma got %0d want %0d",
                                    n_checked, $signed(got.filt), $signed(want.filt)));
        if (got.cal !== want.cal)
          report_mismatch($sformatf("result %0d calibrated got %0d want %0d",
                                    n_checked, got.cal, want.cal));
        if (got.off !== want.off)
          report_mismatch($sformatf("result %0d offset_sum got %0d want %0d",
                                    n_checked, got.off, want.off));
      end
      n_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // Sample side
  // --------------------------------------------------------------------------

  // Offer one sample, optionally after an idle burst, and hold it until the
  // transaction is taken. A typed expectation replaces the model's result.
  task automatic send_sample(input logic m, input logic c,
                             input logic [SAMPLE_W-1:0] s, input bit idle_ok,
                             input bit use_typed, input blk_result_t typed);
    int gap;
    blk_result_t r;
    @(negedge clk);
    if (idle_ok && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    channel  <= c;
    sample   <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
    n_samples++;
    if (fold_sample(m, c, s, r)) begin
      n_blocks++;
      if (r.cal) n_cal++;
      blocks_due.push_back(use_typed ? typed : r);
    end
  endtask

  // Drop valid and wait for every outstanding result, plus the closing
  // steps of a block still in flight.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (blocks_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == hcsf_pkg::REG_GAIN) gain_q = data[GAIN_W-1:0];
    else alpha_q = data[ALPHA_W-1:0];
    n_writes++;
  endtask

  // Random register setting: favor the extremes, junk in the unused bits
  task automatic random_config;
    logic [GAIN_W-1:0]  g;
    logic [ALPHA_W-1:0] a;
    case ($urandom_range(0, 5))
      0: g = '0;
      1: g = GAIN_MAX;
      2: g = GAIN_RESET;
      3: g = GAIN_W'($urandom_range(0, 2**GAIN_W - 1));
      default: g = GAIN_W'($urandom_range(1000, 250000));
    endcase
    case ($urandom_range(0, 5))
      0: a = '0;
      1: a = ALPHA_ONE;
      2: a = ALPHA_MAX;
      3: a = ALPHA_W'($urandom_range(257, 2**ALPHA_W - 1));
      default: a = ALPHA_W'($urandom_range(1, 255));
    endcase
    write_reg(hcsf_pkg::REG_GAIN, g);
    write_reg(hcsf_pkg::REG_ALPHA, {11'($urandom), a});
  endtask

  // One random segment: per-channel signal levels with jitter, a mix of
  // measurement and calibration, and a channel bias.
  task automatic run_segment(input int count, input bit idle_ok);
    bit cal_seg;
    int ch_bias;
    int level [2];
    int v;
    logic m;
    logic c;
    cal_seg  = ($urandom_range(0, 3) == 0);
    ch_bias  = $urandom_range(0, 2) == 0 ? 50 : $urandom_range(15, 85);
    level[0] = $urandom_range(0, 4095);
    level[1] = $urandom_range(0, 4095);
    for (int i = 0; i < count; i++) begin
      m = cal_seg ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 99) < 5);
      c = ($urandom_range(0, 99) < ch_bias) ? CH_BATTERY : CH_SOLAR;
      if ($urandom_range(0, 4) == 0) begin
        v = $urandom_range(0, 4095);
      end else begin
        v = level[c] + int'($urandom_range(0, 127)) - 64;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
      send_sample(m, c, v[SAMPLE_W-1:0], idle_ok, 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic m;
    logic [SAMPLE_W-1:0] s;
    bit idle_ok;

    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    mode       = MODE_MEASURE;
    channel    = CH_SOLAR;
    sample     = '0;
    out_stall  = 1'b0;
    stall_left = 0;
    rx_idling  = 1'b1;
    n_samples  = 0;
    n_blocks   = 0;
    n_cal      = 0;
    n_writes   = 0;
    n_checked  = 0;
    n_errors   = 0;

    gain_q     = GAIN_RESET;
    alpha_q    = ALPHA_RESET;
    sum_acc    = '{'0, '0};
    sample_cnt = '{0, 0};
    filt_ma    = '{'0, '0};
    offset_q   = hcsf_pkg::QUIESCENT_RESET;
    solar_zero = '0;

    // Whole blocks: gain, alpha, pattern, last mode, channel, level, and
    // the typed result where it is plain from the arithmetic.
    dir_table = '{
      // zero input at the reset offset and gain
      '{GAIN_RESET, ALPHA_RESET, PAT_CONST, MODE_MEASURE, CH_SOLAR, 12'd0, 1'b1,
        '{CH_SOLAR, 17'd0, -19'sd118181, -19'sd23544, 1'b0, 17'd61946}},
      '{GAIN_RESET, ALPHA_RESET, PAT_CONST, MODE_MEASURE, CH_BATTERY, 12'd4095,
        1'b0, '0},
      // solar zero point; earlier samples of the block alternate the mode
      '{GAIN_RESET, ALPHA_RESET, PAT_MIXMODE, MODE_CAL, CH_SOLAR, 12'd2000,
        1'b0, '0},
      // battery block that ends in measure must not calibrate
      '{GAIN_RESET, ALPHA_RESET, PAT_MIXMODE, MODE_MEASURE, CH_BATTERY, 12'd1500,
        1'b0, '0},
      // battery calibration: offset becomes (64000 + 67200) / 2
      '{GAIN_RESET, ALPHA_RESET, PAT_CONST, MODE_CAL, CH_BATTERY, 12'd2100,
        1'b0, '0},
      // full gain, filter follows: clamp at both ends
      '{GAIN_MAX, ALPHA_ONE, PAT_CONST, MODE_MEASURE, CH_BATTERY, 12'd4095, 1'b1,
        '{CH_BATTERY, 17'd131040, 19'sd250000, 19'sd250000, 1'b0, 17'd65600}},
      '{GAIN_MAX, ALPHA_ONE, PAT_CONST, MODE_MEASURE, CH_SOLAR, 12'd0, 1'b1,
        '{CH_SOLAR, 17'd0, -19'sd250000, -19'sd250000, 1'b0, 17'd65600}},
      // alpha above one
      '{GAIN_MAX, ALPHA_MAX, PAT_ALT, MODE_MEASURE, CH_BATTERY, 12'd0, 1'b0, '0},
      // zero gain and zero alpha: current reads zero, filter holds
      '{20'd0, 9'd0, PAT_RANDOM, MODE_MEASURE, CH_SOLAR, 12'd0, 1'b0, '0},
      '{20'd0, 9'd0, PAT_CONST, MODE_MEASURE, CH_SOLAR, 12'd4095, 1'b1,
        '{CH_SOLAR, 17'd131040, 19'sd0, -19'sd250000, 1'b0, 17'd65600}},
      // calibration with noisy blocks
      '{GAIN_RESET, ALPHA_RESET, PAT_RANDOM, MODE_CAL, CH_SOLAR, 12'd0, 1'b0, '0},
      '{GAIN_RESET, ALPHA_RESET, PAT_RANDOM, MODE_CAL, CH_BATTERY, 12'd0, 1'b0, '0}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed blocks; change registers only with the block idle
    foreach (dir_table[r]) begin
      if (dir_table[r].gain != gain_q || dir_table[r].alpha != alpha_q) begin
        drain();
        if (dir_table[r].gain != gain_q)
          write_reg(hcsf_pkg::REG_GAIN, CFG_W'(dir_table[r].gain));
        if (dir_table[r].alpha != alpha_q)
          write_reg(hcsf_pkg::REG_ALPHA, CFG_W'(dir_table[r].alpha));
      end
      for (int k = 0; k < BLOCK_LEN; k++) begin
        m = dir_table[r].mode;
        s = dir_table[r].level;
        case (dir_table[r].pat)
          PAT_ALT:     if (k % 2) s = ~s;
          PAT_MIXMODE: m = m ^ logic'((BLOCK_LEN - 1 - k) % 2);
          PAT_RANDOM:  s = SAMPLE_W'($urandom_range(0, 4095));
          default:     ;
        endcase
        send_sample(m, dir_table[r].ch, s, 1'b1,
                    dir_table[r].has_exp && k == BLOCK_LEN - 1, dir_table[r].want);
      end
    end

    // Random segments; each starts from an empty pipeline with a new setting
    while (n_samples < N_ITEMS - TAIL_LEN) begin
      drain();
      random_config();
      rx_idling = ($urandom_range(0, 3) != 0);
      idle_ok   = ($urandom_range(0, 3) != 0);
      run_segment(160, idle_ok);
    end

    // Closing segment at full rate on both sides
    drain();
    random_config();
    rx_idling = 1'b0;
    run_segment(TAIL_LEN, 1'b0);

    drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d samples closing %0d blocks (%0d calibrations), %0d results checked",
             n_samples, n_blocks, n_cal, n_checked);
    $display("Wrote %0d registers across directed and random settings", n_writes);
    if (n_errors == 0 && blocks_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
